// ===== hw/rtl/sbc_pkg.sv =====
// Shared types, constants and round functions for the SHA-512 block compression unit.
// Used by sbc_ctrl, sbc_datapath and the top level; depends on nothing.
`default_nettype none

package sbc_pkg;

  localparam int unsigned SBC_WORD_W      = 64;
  localparam int unsigned SBC_HASH_WORDS  = 8;
  localparam int unsigned SBC_BLOCK_WORDS = 16;
  localparam int unsigned SBC_ROUNDS      = 80;
  localparam int unsigned SBC_HIDX_W      = $clog2(SBC_HASH_WORDS);
  localparam int unsigned SBC_WCNT_W      = $clog2(SBC_BLOCK_WORDS);
  localparam int unsigned SBC_RCNT_W      = $clog2(SBC_ROUNDS + 1);

  localparam logic [SBC_RCNT_W-1:0] SBC_LAST_ROUND = SBC_RCNT_W'(SBC_ROUNDS - 1);
  localparam logic [SBC_WCNT_W-1:0] SBC_LAST_WORD  = SBC_WCNT_W'(SBC_BLOCK_WORDS - 1);
  localparam logic [SBC_HIDX_W-1:0] SBC_LAST_HIDX  = SBC_HIDX_W'(SBC_HASH_WORDS - 1);

  // Opcodes of an input beat
  localparam logic OP_LOAD_HASH = 1'b0;
  localparam logic OP_ABSORB    = 1'b1;

  typedef logic [SBC_WORD_W-1:0] word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                  load_hash;  // write one chaining word
    logic                  shift_msg;  // push a byte-swapped message word
    logic                  init;       // copy hash into working vars, prime K+W
    logic                  round;      // run one compression round
    logic [SBC_RCNT_W-1:0] k_idx;      // round constant for the next K+W sum
    logic                  finalize;   // add working vars into the hash
    logic                  emit;       // put one digest word on the result ports
    logic [SBC_HIDX_W-1:0] emit_idx;
  } sbc_cmd_t;

  function automatic word_t rotr(input word_t v, input int unsigned n);
    rotr = (v >> n) | (v << (SBC_WORD_W - n));
  endfunction

  function automatic word_t big_sigma0(input word_t v);
    big_sigma0 = rotr(v, 28) ^ rotr(v, 34) ^ rotr(v, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t v);
    big_sigma1 = rotr(v, 14) ^ rotr(v, 18) ^ rotr(v, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t v);
    small_sigma0 = rotr(v, 1) ^ rotr(v, 8) ^ (v >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t v);
    small_sigma1 = rotr(v, 19) ^ rotr(v, 61) ^ (v >> 6);
  endfunction

  // Memory byte 0 sits in bits 7..0; move it to the top byte
  function automatic word_t byte_swap(input word_t v);
    word_t r;
    r = '0;
    for (int i = 0; i < SBC_WORD_W / 8; i++) begin
      r[SBC_WORD_W-1-8*i -: 8] = v[8*i +: 8];
    end
    byte_swap = r;
  endfunction

  // Round constants; codes past the last round read as zero
  function automatic word_t round_k(input logic [SBC_RCNT_W-1:0] idx);
    word_t k;
    case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    round_k = k;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sha512_block_compress_unit.sv =====
// Top level of the SHA-512 block compression unit: controller plus datapath.
// Depends on sbc_pkg, sbc_ctrl and sbc_datapath.
//
// Usage: a beat is taken at a rising edge with start_i high and busy_o low.
// opcode_i = 0 writes chaining word hash_index_i with data_word_i; opcode_i = 1
// absorbs data_word_i as a message word in memory byte order (byte 0 in bits
// 7..0), swapped to big-endian on entry. Hash loads and the first fifteen
// message words of a block leave busy_o low. The sixteenth word starts a
// compression: a setup step, 80 rounds at one per cycle, a step that adds
// the working variables into the chaining hash, then an emit step for each
// of the eight digest words. busy_o is high from setup through the emits.
// Results appear on digest_word_o/digest_index_o with digest_valid_o high for
// one cycle each, index 0 first, on consecutive cycles; last_word_o marks
// index 7. No new beat is taken before the last digest word is emitted.
// The receiver cannot stall; results are shown once and must be taken.
// Reset clears the chaining hash, working variables and word count; the
// message schedule holds no reset value and is always rewritten before use.
`default_nettype none

module sha512_block_compress_unit (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start_i,
  output logic                                         busy_o,
  input  wire logic                                    opcode_i,
  input  wire logic [sbc_pkg::SBC_HIDX_W-1:0]          hash_index_i,
  input  wire sbc_pkg::word_t                          data_word_i,
  output logic                                         digest_valid_o,
  output sbc_pkg::word_t                               digest_word_o,
  output logic [sbc_pkg::SBC_HIDX_W-1:0]               digest_index_o,
  output logic                                         last_word_o
);

  sbc_pkg::sbc_cmd_t cmd;

  sbc_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  sbc_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .hash_index_i   (hash_index_i),
    .data_word_i    (data_word_i),
    .digest_valid_o (digest_valid_o),
    .digest_word_o  (digest_word_o),
    .digest_index_o (digest_index_o),
    .last_word_o    (last_word_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sbc_ctrl.sv =====
// Controller of the SHA-512 block compression unit: word count, round count, emit sequence.
// Depends on sbc_pkg; drives the command struct of sbc_datapath.
`default_nettype none

module sbc_ctrl (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start_i,
  input  wire logic                                    opcode_i,
  output logic                                         busy_o,
  output sbc_pkg::sbc_cmd_t                            cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_INIT  = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FINAL = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]                        state_q, state_d;
  logic [sbc_pkg::SBC_RCNT_W-1:0]    cnt_q, cnt_d;
  logic [sbc_pkg::SBC_WCNT_W-1:0]    word_cnt_q, word_cnt_d;
  logic                              accept;

  assign accept = start_i && (state_q == ST_IDLE);
  assign busy_o = (state_q != ST_IDLE);

  // Next state, counters and datapath commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    word_cnt_d = word_cnt_q;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (opcode_i == sbc_pkg::OP_LOAD_HASH) begin
            cmd_o.load_hash = 1'b1;
          end else begin
            cmd_o.shift_msg = 1'b1;
            if (word_cnt_q == sbc_pkg::SBC_LAST_WORD) begin
              word_cnt_d = '0;
              state_d    = ST_INIT;
            end else begin
              word_cnt_d = word_cnt_q + 1'b1;
            end
          end
        end
      end
      ST_INIT: begin
        cmd_o.init  = 1'b1;
        cmd_o.k_idx = '0;
        cnt_d       = '0;
        state_d     = ST_ROUND;
      end
      ST_ROUND: begin
        // prime K+W for the round after this one
        cmd_o.round = 1'b1;
        cmd_o.k_idx = cnt_q + 1'b1;
        if (cnt_q == sbc_pkg::SBC_LAST_ROUND) begin
          state_d = ST_FINAL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINAL: begin
        cmd_o.finalize = 1'b1;
        cnt_d          = '0;
        state_d        = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit     = 1'b1;
        cmd_o.emit_idx = cnt_q[sbc_pkg::SBC_HIDX_W-1:0];
        if (cnt_q[sbc_pkg::SBC_HIDX_W-1:0] == sbc_pkg::SBC_LAST_HIDX) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      word_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      word_cnt_q <= word_cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sbc_datapath.sv =====
// Datapath of the SHA-512 block compression unit: chaining hash, working vars,
// schedule window, round logic and result register. Depends on sbc_pkg.
`default_nettype none

module sbc_datapath (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire sbc_pkg::sbc_cmd_t                       cmd_i,
  input  wire logic [sbc_pkg::SBC_HIDX_W-1:0]          hash_index_i,
  input  wire sbc_pkg::word_t                          data_word_i,
  output logic                                         digest_valid_o,
  output sbc_pkg::word_t                               digest_word_o,
  output logic [sbc_pkg::SBC_HIDX_W-1:0]               digest_index_o,
  output logic                                         last_word_o
);

  sbc_pkg::word_t hash_q [sbc_pkg::SBC_HASH_WORDS];
  sbc_pkg::word_t v_q    [sbc_pkg::SBC_HASH_WORDS];
  sbc_pkg::word_t w_q    [sbc_pkg::SBC_BLOCK_WORDS];
  sbc_pkg::word_t kw_q;
  sbc_pkg::word_t out_word_q;
  logic [sbc_pkg::SBC_HIDX_W-1:0] out_idx_q;
  logic                           out_last_q;
  logic                           out_valid_q;

  sbc_pkg::word_t t1, t2, w_new, ch, maj;

  // Round and schedule arithmetic
  always_comb begin
    ch    = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    maj   = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1    = v_q[7] + sbc_pkg::big_sigma1(v_q[4]) + ch + kw_q;
    t2    = sbc_pkg::big_sigma0(v_q[0]) + maj;
    w_new = sbc_pkg::small_sigma1(w_q[14]) + w_q[9] + sbc_pkg::small_sigma0(w_q[1]) + w_q[0];
  end

  // Chaining hash and working variables
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sbc_pkg::SBC_HASH_WORDS; i++) begin
        hash_q[i] <= '0;
        v_q[i]    <= '0;
      end
    end else begin
      if (cmd_i.load_hash) begin
        hash_q[hash_index_i] <= data_word_i;
      end
      if (cmd_i.init) begin
        for (int i = 0; i < sbc_pkg::SBC_HASH_WORDS; i++) begin
          v_q[i] <= hash_q[i];
        end
      end
      if (cmd_i.round) begin
        v_q[7] <= v_q[6];
        v_q[6] <= v_q[5];
        v_q[5] <= v_q[4];
        v_q[4] <= v_q[3] + t1;
        v_q[3] <= v_q[2];
        v_q[2] <= v_q[1];
        v_q[1] <= v_q[0];
        v_q[0] <= t1 + t2;
      end
      if (cmd_i.finalize) begin
        for (int i = 0; i < sbc_pkg::SBC_HASH_WORDS; i++) begin
          hash_q[i] <= hash_q[i] + v_q[i];
        end
      end
    end
  end

  // Schedule window: tap 0 holds the word of the current round
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_msg || cmd_i.round) begin
      for (int i = 0; i < sbc_pkg::SBC_BLOCK_WORDS - 1; i++) begin
        w_q[i] <= w_q[i+1];
      end
      w_q[sbc_pkg::SBC_BLOCK_WORDS-1] <= cmd_i.shift_msg ? sbc_pkg::byte_swap(data_word_i)
                                                         : w_new;
    end
    // K+W one round ahead
    if (cmd_i.init) begin
      kw_q <= sbc_pkg::round_k(cmd_i.k_idx) + w_q[0];
    end else if (cmd_i.round) begin
      kw_q <= sbc_pkg::round_k(cmd_i.k_idx) + w_q[1];
    end
  end

  // Result register: payload without reset, strobe with
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_word_q <= hash_q[cmd_i.emit_idx];
      out_idx_q  <= cmd_i.emit_idx;
      out_last_q <= (cmd_i.emit_idx == sbc_pkg::SBC_LAST_HIDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit;
    end
  end

  assign digest_valid_o = out_valid_q;
  assign digest_word_o  = out_word_q;
  assign digest_index_o = out_idx_q;
  assign last_word_o    = out_last_q & out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sbc_checker.sv =====
// Port-level checks for the SHA-512 block compression unit, bound to the top level.
// Depends on sbc_pkg and sha512_block_compress_unit.
`default_nettype none

module sbc_checker (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    start_i,
  input  wire logic                                    busy_o,
  input  wire logic                                    opcode_i,
  input  wire logic                                    digest_valid_o,
  input  wire logic [sbc_pkg::SBC_HIDX_W-1:0]          digest_index_o,
  input  wire logic                                    last_word_o
);

  // Digest beats run back to back until the last one
  a_burst_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o && !last_word_o |=> digest_valid_o)
    else $error("digest burst broken before last word");

  // Indices count up by one within a burst
  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o && !last_word_o |=>
      digest_index_o == sbc_pkg::SBC_HIDX_W'($past(digest_index_o) + 1'b1))
    else $error("digest index out of sequence");

  // Last-word flag marks exactly the final index
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o |-> (last_word_o == (digest_index_o == sbc_pkg::SBC_LAST_HIDX)))
    else $error("last_word_o does not match digest index");

  // A burst opens only after a busy compression
  a_burst_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    digest_valid_o && (digest_index_o == '0) |-> $past(busy_o))
    else $error("digest emitted without a compression");

  // A hash load never triggers results
  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (opcode_i == sbc_pkg::OP_LOAD_HASH) |=> !digest_valid_o)
    else $error("results after a hash load");

endmodule

bind sha512_block_compress_unit sbc_checker u_sbc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .opcode_i       (opcode_i),
  .digest_valid_o (digest_valid_o),
  .digest_index_o (digest_index_o),
  .last_word_o    (last_word_o)
);

`default_nettype wire
